>>> sv/assert_macros.svh
// Assertion macros used by the top-level RTL file of the window range run tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

>>> sv/wrrt_pkg.sv
// Shared constants, types and helper functions of the window range run tracker.
package wrrt_pkg;

	localparam int HISTORY_DEPTH = 1024;
	localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
	localparam int LEN_W         = $clog2(HISTORY_DEPTH + 2);
	localparam int SAMPLE_W      = 32;
	localparam int LIMIT_W       = 31;
	localparam int OUT_LEN_W     = 11;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 24;

	typedef logic [ADDR_W-1:0]          addr_t;
	typedef logic [LEN_W-1:0]           len_t;
	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [LIMIT_W-1:0]         limit_t;

	localparam len_t DEPTH_LEN = LEN_W'(HISTORY_DEPTH);

	typedef struct packed {
		logic accept;
		logic upd;
		logic walk_init;
		logic walk_step;
		logic fin;
	} cmd_t;

	typedef struct packed {
		logic len_zero;
		logic len_full;
		logic limit_zero;
		logic range_hit;
		logic walk_empty;
		logic walk_last;
		logic out_free;
	} status_t;

	function automatic addr_t ptr_dec(addr_t p);
		return (p == '0) ? addr_t'(HISTORY_DEPTH - 1) : p - addr_t'(1);
	endfunction

	function automatic addr_t ptr_inc(addr_t p);
		return (p == addr_t'(HISTORY_DEPTH - 1)) ? '0 : p + addr_t'(1);
	endfunction

	// exact hi - lo >= lim, no wraparound
	function automatic logic range_ge(sample_t hi, sample_t lo, limit_t lim);
		logic signed [SAMPLE_W:0] diff;
		diff = {hi[SAMPLE_W-1], hi} - {lo[SAMPLE_W-1], lo};
		return diff >= $signed({2'b00, lim});
	endfunction

endpackage

>>> sv/wrrt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module wrrt_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/wrrt_ctrl.sv
// Controller state machine of the window range run tracker.
module wrrt_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  wrrt_pkg::status_t status,
	output wrrt_pkg::cmd_t    cmd
);

	import wrrt_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_UPD   = 6'b000010,
		ST_CHK   = 6'b000100,
		ST_WINIT = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_FIN   = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		in_ready      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				priority if (status.len_zero) begin
					state_d = status.limit_zero ? ST_WINIT : ST_FIN;
				end else if (status.len_full) begin
					state_d = ST_WINIT;
				end else begin
					state_d = ST_CHK;
				end
			end
			ST_CHK: begin
				state_d = status.range_hit ? ST_WINIT : ST_FIN;
			end
			ST_WINIT: begin
				cmd.walk_init = 1'b1;
				state_d       = status.walk_empty ? ST_FIN : ST_WALK;
			end
			ST_WALK: begin
				cmd.walk_step = 1'b1;
				if (status.walk_last) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				cmd.fin = status.out_free;
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> sv/wrrt_dp.sv
// Datapath of the window range run tracker: run state, history walk and result register.
module wrrt_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [wrrt_pkg::LIMIT_W-1:0]      cfg_wr_data,
	input  logic [wrrt_pkg::SAMPLE_W-1:0]     in_sample,
	input  logic                              in_restart,
	input  wrrt_pkg::cmd_t                    cmd,
	output wrrt_pkg::status_t                 status,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [wrrt_pkg::OUT_LEN_W-1:0]    out_shortest,
	output logic [wrrt_pkg::OUT_LEN_W-1:0]    out_longest,
	output logic                              out_capped
);

	import wrrt_pkg::*;

	limit_t  limit_q;
	sample_t x_q;
	addr_t   pos_q;
	addr_t   wr_ptr_q;
	addr_t   walk_idx_q;
	len_t    count_q;
	len_t    run_len_q;
	sample_t max_q;
	sample_t min_q;
	logic    bounded_q;
	logic    capped_q;
	len_t    short_q;
	logic    short_vld_q;
	len_t    long_q;

	addr_t   wpos;
	addr_t   raddr;
	sample_t prev;
	len_t    avail;
	len_t    len_inc;
	logic    hit;
	logic    exhaust;
	logic    short_take;
	len_t    new_short;
	logic    new_vld;
	len_t    new_long;

	wrrt_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (HISTORY_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (cmd.accept),
		.waddr (wpos),
		.wdata (in_sample),
		.raddr (raddr),
		.rdata (prev)
	);

	always_comb begin
		wpos    = in_restart ? '0 : wr_ptr_q;
		raddr   = cmd.walk_init ? ptr_dec(pos_q) : walk_idx_q;
		avail   = (count_q > DEPTH_LEN) ? DEPTH_LEN : count_q;
		len_inc = run_len_q + len_t'(1);
		hit     = range_ge(prev, min_q, limit_q) || range_ge(max_q, prev, limit_q);
		exhaust = len_inc >= avail;

		short_take = bounded_q && (!short_vld_q || len_inc < short_q);
		new_short  = short_take ? len_inc : short_q;
		new_vld    = short_vld_q || bounded_q;
		new_long   = (run_len_q > long_q) ? run_len_q : long_q;

		status.len_zero   = run_len_q == '0;
		status.len_full   = run_len_q >= DEPTH_LEN;
		status.limit_zero = limit_q == '0;
		status.range_hit  = range_ge(max_q, min_q, limit_q);
		status.walk_empty = avail <= len_t'(1);
		status.walk_last  = hit || exhaust;
		status.out_free   = !out_valid || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= limit_t'(1);
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			count_q     <= '0;
			run_len_q   <= '0;
			max_q       <= '0;
			min_q       <= '0;
			bounded_q   <= 1'b0;
			capped_q    <= 1'b0;
			short_vld_q <= 1'b0;
			long_q      <= '0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.accept) begin
				wr_ptr_q <= ptr_inc(wpos);
				if (in_restart) begin
					count_q     <= len_t'(1);
					run_len_q   <= '0;
					max_q       <= '0;
					min_q       <= '0;
					bounded_q   <= 1'b0;
					capped_q    <= 1'b0;
					short_vld_q <= 1'b0;
					long_q      <= '0;
				end else if (count_q <= DEPTH_LEN) begin
					count_q <= count_q + len_t'(1);
				end
			end
			if (cmd.upd) begin
				priority if (run_len_q == '0) begin
					max_q     <= x_q;
					min_q     <= x_q;
					run_len_q <= len_t'(1);
					bounded_q <= 1'b0;
				end else if (run_len_q < DEPTH_LEN) begin
					if (x_q > max_q) begin
						max_q <= x_q;
					end
					if (x_q < min_q) begin
						min_q <= x_q;
					end
					run_len_q <= len_inc;
				end else begin
					run_len_q <= run_len_q;
				end
			end
			if (cmd.walk_init) begin
				max_q     <= x_q;
				min_q     <= x_q;
				run_len_q <= len_t'(1);
				bounded_q <= 1'b0;
			end
			if (cmd.walk_step) begin
				if (hit) begin
					bounded_q <= 1'b1;
				end else begin
					if (prev > max_q) begin
						max_q <= prev;
					end
					if (prev < min_q) begin
						min_q <= prev;
					end
					run_len_q <= len_inc;
					// history ran out while older samples existed
					if (exhaust && count_q > DEPTH_LEN) begin
						capped_q <= 1'b1;
					end
				end
			end
			if (cmd.fin) begin
				short_q     <= new_short;
				short_vld_q <= new_vld;
				long_q      <= new_long;
				out_valid   <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			x_q   <= in_sample;
			pos_q <= wpos;
		end
		if (cmd.walk_init) begin
			walk_idx_q <= ptr_dec(ptr_dec(pos_q));
		end else if (cmd.walk_step) begin
			walk_idx_q <= ptr_dec(walk_idx_q);
		end
		if (cmd.fin) begin
			if (status.limit_zero) begin
				out_shortest <= OUT_LEN_W'(1);
				out_longest  <= '0;
			end else begin
				out_shortest <= new_vld ? OUT_LEN_W'(new_short) : '0;
				out_longest  <= OUT_LEN_W'(new_long);
			end
			out_capped <= capped_q;
		end
	end

endmodule

>>> sv/window_range_run_tracker.sv
// Window range run tracker top level: controller, datapath and stream ports.
// Each accepted sample passes UPD, then CHK unless the run was empty or full, and then FIN;
// a rebuild adds WINIT plus a WALK that visits stored samples (up to depth - 1) through
// the single history RAM read port; s_tready is low from accept until FIN hands off a result.
// Reset (arst_n, async active low) clears run state and m_tvalid and sets range_limit to 1;
// result data and history RAM contents are not cleared; the RAM is never read before being written.
`include "assert_macros.svh"

module window_range_run_tracker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [wrrt_pkg::LIMIT_W-1:0]        cfg_wr_data,  // range_limit
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [wrrt_pkg::IN_TDATA_W-1:0]     s_tdata,      // [31:0] sample
	input  logic                                s_tuser,      // restart
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [wrrt_pkg::OUT_TDATA_W-1:0]    m_tdata,      // [10:0] shortest_len, [21:11] longest_len
	output logic                                m_tuser       // window_capped
);

	import wrrt_pkg::*;

	cmd_t                 cmd;
	status_t              status;
	logic [OUT_LEN_W-1:0] shortest;
	logic [OUT_LEN_W-1:0] longest;

	wrrt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	wrrt_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.in_sample    (s_tdata[SAMPLE_W-1:0]),
		.in_restart   (s_tuser),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_shortest (shortest),
		.out_longest  (longest),
		.out_capped   (m_tuser)
	);

	assign m_tdata = {{(OUT_TDATA_W - 2 * OUT_LEN_W){1'b0}}, longest, shortest};

	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready, !s_tready)
	`ASSERT_IMPLIES(a_fin_needs_room, clk, arst_n, cmd.fin, !m_tvalid || m_tready)
	`ASSERT_IMPLIES(a_single_cmd, clk, arst_n, 1'b1, ($onehot0({cmd.accept, cmd.upd, cmd.walk_init, cmd.walk_step, cmd.fin})))

endmodule
